// ===== rtl/trace_ring_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// trace ring buffer assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef TRACE_RING_BUFFER_DEFINES_SVH
`define TRACE_RING_BUFFER_DEFINES_SVH

// same-cycle implication
`define TRB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trace ring buffer assertion failed");

// next-cycle implication
`define TRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trace ring buffer assertion failed");

`endif

// ===== rtl/trb_pkg.sv =====
// ----------------------------------------------------------------------------
// trb_pkg
// shared codes, entry layout and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none
package trb_pkg;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_SEARCH = 3'd2;
  localparam logic [2:0] CMD_COUNT  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_HIDDEN = 2'd2;

  localparam logic [1:0] REG_FILTER = 2'd0;
  localparam logic [1:0] REG_SIZE   = 2'd1;
  localparam logic [1:0] REG_MLOW   = 2'd2;
  localparam logic [1:0] REG_MHIGH  = 2'd3;

  localparam logic [31:0] KEY_NEVER = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] number;
    logic [63:0] stamp;
    logic [31:0] payload;
    logic        hidden;
  } entry_t;

  typedef struct packed {
    logic start;
    logic exec;
    logic walk_init;
    logic rd;
    logic chk;
  } ctl_t;

  typedef struct packed {
    logic walk;
    logic done;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/trace_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// trace_ring_buffer
// circular trace store with event numbering, lookup, search and count
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one command word per valid/ready handshake; out_* returns
//   exactly one result word per command. cfg_we writes one register per cycle
//   (0 filter, 1 ring size, 2 low mask, 3 high mask); the user must do so only
//   while idle, the block does not enforce it. append, clear, unfiltered count,
//   unknown commands, lookups at or past the fill count, KEY_NEVER searches and
//   commands on an empty ring go from decode straight to finish; other lookups,
//   searches and filtered counts walk the ring through the single entry memory
//   read port, one read and one check step per entry, visiting one entry
//   (unfiltered lookup) or up to fill. one command is worked on at a time; the
//   next word is accepted the cycle after the result is loaded into the output
//   register. reset clears the write pointer, fill count, event counter and
//   versions; entry memory is not cleared and is never read before being
//   written. when the receiver stalls the result holds and the next finished
//   command waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module trace_ring_buffer #(
  parameter int DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [9:0]  in_position,
  input  wire logic [31:0] in_event_key,
  input  wire logic [63:0] in_stamp_in,
  input  wire logic [31:0] in_payload_in,
  input  wire logic        in_hide_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [10:0]      out_place,
  output logic [31:0]      out_number_out,
  output logic [63:0]      out_stamp_out,
  output logic [31:0]      out_payload_out,
  output logic             out_hidden_out,
  output logic             out_notify
);

  trb_pkg::ctl_t ctl;
  trb_pkg::sts_t sts;
  logic          load_out;

  trb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .load_out  (load_out),
    .sts       (sts)
  );

  trb_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .load_out        (load_out),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_event_key    (in_event_key),
    .in_stamp_in     (in_stamp_in),
    .in_payload_in   (in_payload_in),
    .in_hide_in      (in_hide_in),
    .out_status      (out_status),
    .out_place       (out_place),
    .out_number_out  (out_number_out),
    .out_stamp_out   (out_stamp_out),
    .out_payload_out (out_payload_out),
    .out_hidden_out  (out_hidden_out),
    .out_notify      (out_notify)
  );

endmodule
`default_nettype wire

// ===== rtl/trb_ctrl.sv =====
// ----------------------------------------------------------------------------
// trb_ctrl
// command sequencer: decode, ring walk read/check steps, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "trace_ring_buffer_defines.svh"
module trb_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output trb_pkg::ctl_t     ctl,
  output logic              load_out,
  input  wire trb_pkg::sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_RD, S_CHK, S_FIN} state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    ctl           = '0;
    ctl.start     = in_valid && (state_r == S_IDLE);
    ctl.exec      = (state_r == S_DEC) && !sts.walk;
    ctl.walk_init = (state_r == S_DEC) && sts.walk;
    ctl.rd        = (state_r == S_RD);
    ctl.chk       = (state_r == S_CHK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_DEC;
        S_DEC:  state_r <= sts.walk ? S_RD : S_FIN;
        S_RD:   state_r <= S_CHK;
        S_CHK:  state_r <= sts.done ? S_FIN : S_RD;
        S_FIN:  if (load_out) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `TRB_ASSERT_IMPL(chk_follows_rd, state_r == S_CHK, $past(state_r) == S_RD)
  `TRB_ASSERT_NEXT(accept_to_decode, in_valid && in_ready, state_r == S_DEC)
  `TRB_ASSERT_NEXT(load_sets_valid, load_out, out_valid_r)

endmodule
`default_nettype wire

// ===== rtl/trb_dpath.sv =====
// ----------------------------------------------------------------------------
// trb_dpath
// entry memory, ring pointers, counters, config registers and result regs
// ----------------------------------------------------------------------------
`default_nettype none
`include "trace_ring_buffer_defines.svh"
module trb_dpath #(
  parameter int DEPTH = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire trb_pkg::ctl_t ctl,
  input  wire logic          load_out,
  output trb_pkg::sts_t      sts,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  input  wire logic [2:0]    in_cmd,
  input  wire logic [9:0]    in_position,
  input  wire logic [31:0]   in_event_key,
  input  wire logic [63:0]   in_stamp_in,
  input  wire logic [31:0]   in_payload_in,
  input  wire logic          in_hide_in,
  output logic [1:0]         out_status,
  output logic [10:0]        out_place,
  output logic [31:0]        out_number_out,
  output logic [63:0]        out_stamp_out,
  output logic [31:0]        out_payload_out,
  output logic               out_hidden_out,
  output logic               out_notify
);

  localparam int AW   = $clog2(DEPTH);
  localparam int NRST = (DEPTH < 1024) ? DEPTH : 1024;

  trb_pkg::entry_t mem [DEPTH];
  trb_pkg::entry_t rdata_r;

  logic [AW-1:0] ws_r;
  logic [AW:0]   fill_r, n_r, u_r, f_r;
  logic [AW-1:0] addr_r;
  logic [31:0]   ec_r;
  logic [63:0]   ver_a_r, ver_b_r;
  logic          filter_r;
  logic [31:0]   mlow_r, mhigh_r;

  logic [2:0]    cmd_r;
  logic [9:0]    pos_r;
  logic [31:0]   key_r, pay_in_r;
  logic [63:0]   stamp_in_r;
  logic          hide_in_r;

  // pending result
  logic [1:0]  res_status_r;
  logic [10:0] res_place_r;
  logic [31:0] res_number_r, res_payload_r;
  logic [63:0] res_stamp_r;
  logic        res_hidden_r, res_notify_r;

  logic [31:0] fill32, pos32, ec1, n32, place32, u32, f32, fnext32, nsz;
  logic [31:0] phys32, start32;
  logic [AW:0] u1, fnext;
  logic        last, hit;

  always_comb begin
    fill32  = 32'(fill_r);
    pos32   = 32'(pos_r);
    n32     = 32'(n_r);
    u32     = 32'(u_r);
    f32     = 32'(f_r);
    ec1     = ec_r + 32'd1;
    // newest-first slot of position pos (pos below fill, fill at most n)
    phys32  = 32'(ws_r) + n32 - 32'd1 - pos32;
    if (phys32 >= n32) phys32 = phys32 - n32;
    start32 = 32'(ws_r) + n32 - 32'd1;
    if (start32 >= n32) start32 = start32 - n32;
    nsz = 32'(cfg_data[10:0]);
    if (nsz == 32'd0) nsz = 32'd1;
    else if (nsz > 32'(DEPTH)) nsz = 32'(DEPTH);

    sts.walk = 1'b0;
    case (cmd_r)
      // visible entries never outnumber stored ones
      trb_pkg::CMD_LOOKUP: sts.walk = (fill_r != '0) && (pos32 < fill32);
      trb_pkg::CMD_SEARCH: sts.walk = (fill_r != '0) && (key_r != trb_pkg::KEY_NEVER);
      trb_pkg::CMD_COUNT:  sts.walk = (fill_r != '0) && filter_r;
      default:             sts.walk = 1'b0;
    endcase

    u1    = u_r + 1'b1;
    last  = (u1 == fill_r);
    fnext = f_r;
    hit   = 1'b0;
    case (cmd_r)
      trb_pkg::CMD_LOOKUP: begin
        hit = !filter_r || (!rdata_r.hidden && (f_r == '0));
        if (!rdata_r.hidden) fnext = f_r - 1'b1;
      end
      trb_pkg::CMD_SEARCH: begin
        hit = (rdata_r.number == key_r);
        if (!rdata_r.hidden) fnext = f_r + 1'b1;
      end
      trb_pkg::CMD_COUNT: begin
        if (!rdata_r.hidden) fnext = f_r + 1'b1;
      end
      default: hit = 1'b0;
    endcase
    fnext32  = 32'(fnext);
    sts.done = hit || last;
    place32  = fill32;
  end

  // entry store
  always_ff @(posedge clk) begin
    if (ctl.exec && (cmd_r == trb_pkg::CMD_APPEND)) begin
      mem[ws_r] <= '{number: ec1, stamp: stamp_in_r, payload: pay_in_r,
                     hidden: hide_in_r};
    end
    if (ctl.rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r     <= '0;
      fill_r   <= '0;
      ec_r     <= '0;
      ver_a_r  <= '0;
      ver_b_r  <= '0;
      filter_r <= 1'b0;
      n_r      <= (AW+1)'(NRST);
      mlow_r   <= '0;
      mhigh_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          trb_pkg::REG_FILTER: filter_r <= cfg_data[0];
          trb_pkg::REG_SIZE: begin
            n_r    <= nsz[AW:0];
            ws_r   <= '0;
            fill_r <= '0;
          end
          trb_pkg::REG_MLOW:  mlow_r  <= cfg_data;
          trb_pkg::REG_MHIGH: mhigh_r <= cfg_data;
          default: filter_r <= filter_r;
        endcase
      end
      if (ctl.exec) begin
        case (cmd_r)
          trb_pkg::CMD_APPEND: begin
            ec_r <= ec1;
            ws_r <= (32'(ws_r) + 32'd1 == n32) ? '0 : ws_r + 1'b1;
            if (fill_r < n_r) fill_r <= fill_r + 1'b1;
            if ((ec1 & mhigh_r) == 32'd0) begin
              if ((ec1 & mlow_r) != 32'd0) ver_a_r <= ver_a_r + 64'd1;
              else ver_b_r <= ver_b_r + 64'd1;
            end
          end
          trb_pkg::CMD_CLEAR: begin
            ws_r   <= '0;
            fill_r <= '0;
          end
          default: ec_r <= ec_r;
        endcase
      end
    end
  end

  // command latch, walk registers, results
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r      <= in_cmd;
      pos_r      <= in_position;
      key_r      <= in_event_key;
      stamp_in_r <= in_stamp_in;
      pay_in_r   <= in_payload_in;
      hide_in_r  <= in_hide_in;
    end
    if (ctl.exec) begin
      res_status_r  <= trb_pkg::ST_OK;
      res_place_r   <= '0;
      res_number_r  <= '0;
      res_stamp_r   <= '0;
      res_payload_r <= '0;
      res_hidden_r  <= 1'b0;
      res_notify_r  <= 1'b0;
      case (cmd_r)
        trb_pkg::CMD_APPEND: begin
          res_number_r <= ec1;
          res_notify_r <= ((ec1 & mhigh_r) == 32'd0);
        end
        trb_pkg::CMD_COUNT: res_place_r <= filter_r ? 11'd0 : place32[10:0];
        trb_pkg::CMD_CLEAR: res_status_r <= trb_pkg::ST_OK;
        default:            res_status_r <= trb_pkg::ST_NONE;
      endcase
    end
    if (ctl.walk_init) begin
      res_notify_r <= 1'b0;
      f_r <= '0;
      case (cmd_r)
        trb_pkg::CMD_LOOKUP: begin
          u_r <= filter_r ? '0 : pos32[AW:0];
          f_r <= pos32[AW:0];
          addr_r <= filter_r ? start32[AW-1:0] : phys32[AW-1:0];
        end
        trb_pkg::CMD_COUNT: begin
          u_r    <= '0;
          addr_r <= '0;
        end
        default: begin
          u_r    <= '0;
          addr_r <= start32[AW-1:0];
        end
      endcase
    end
    if (ctl.chk) begin
      u_r <= u1;
      f_r <= fnext;
      if (cmd_r == trb_pkg::CMD_COUNT) addr_r <= addr_r + 1'b1;
      else if (addr_r == '0) addr_r <= n32[AW-1:0] - 1'b1;
      else addr_r <= addr_r - 1'b1;
      if (sts.done) begin
        res_status_r  <= trb_pkg::ST_OK;
        res_place_r   <= '0;
        res_number_r  <= '0;
        res_stamp_r   <= '0;
        res_payload_r <= '0;
        res_hidden_r  <= 1'b0;
        case (cmd_r)
          trb_pkg::CMD_LOOKUP: begin
            if (hit) begin
              res_number_r  <= rdata_r.number;
              res_stamp_r   <= rdata_r.stamp;
              res_payload_r <= rdata_r.payload;
              res_hidden_r  <= rdata_r.hidden;
            end else begin
              res_status_r <= trb_pkg::ST_NONE;
            end
          end
          trb_pkg::CMD_SEARCH: begin
            if (!hit) res_status_r <= trb_pkg::ST_NONE;
            else if (!filter_r) res_place_r <= u32[10:0];
            else if (rdata_r.hidden) res_status_r <= trb_pkg::ST_HIDDEN;
            else res_place_r <= f32[10:0];
          end
          default: res_place_r <= fnext32[10:0];
        endcase
      end
    end
    if (load_out) begin
      out_status      <= res_status_r;
      out_place       <= res_place_r;
      out_number_out  <= res_number_r;
      out_stamp_out   <= res_stamp_r;
      out_payload_out <= res_payload_r;
      out_hidden_out  <= res_hidden_r;
      out_notify      <= res_notify_r;
    end
  end

  `TRB_ASSERT_IMPL(fill_within_ring, 1'b1, fill_r <= n_r)
  `TRB_ASSERT_IMPL(slot_within_ring, 1'b1, (AW+1)'(ws_r) < n_r)
  `TRB_ASSERT_IMPL(walk_in_range, ctl.chk, u_r < fill_r)

endmodule
`default_nettype wire
